@@ rtl/mte_pkg.sv @@
// Package for the timer slot table: transfer payload types, opcodes and the
// link record that passes along the row of timer cells. No dependencies.
package mte_pkg;

  localparam int SLOT_W = 4;
  localparam int WORD_W = 32;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [SLOT_W-1:0] slot;
    logic              one_shot;
    logic [WORD_W-1:0] interval;
    logic [WORD_W-1:0] now_time;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] fired_slot;
    logic              fired_once;
    logic              last;
  } result_t;

  // add/delete request broadcast to every cell
  typedef struct packed {
    logic              add;
    logic              del;
    logic [SLOT_W-1:0] slot;
    logic              one_shot;
    logic [WORD_W-1:0] interval;
  } cmd_t;

  // fire report rippled from cell to cell
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              once;
  } link_t;

endpackage

@@ rtl/mte_cell.sv @@
// One timer slot: valid/one-shot marks, interval, start time and the scan token.
// Uses mte_pkg. Instantiated in a row by multi_timer_expiry_table.
module mte_cell #(
  parameter int IDX       = 0,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mte_pkg::cmd_t        cmd,
  input  logic [TIME_BITS-1:0] now,
  input  logic                 adv,
  input  logic                 tok_in,
  output logic                 tok,
  input  mte_pkg::link_t       link_in,
  output mte_pkg::link_t       link_out
);

  localparam int CMP_W = (TIME_BITS > mte_pkg::WORD_W) ? TIME_BITS : mte_pkg::WORD_W;
  localparam bit REACH = IDX < (1 << mte_pkg::SLOT_W);
  localparam logic [mte_pkg::SLOT_W-1:0] ID = mte_pkg::SLOT_W'(IDX);

  logic                       valid;
  logic                       once;
  logic [mte_pkg::WORD_W-1:0] interval;
  logic [TIME_BITS-1:0]       start;
  logic [TIME_BITS-1:0]       elapsed;
  logic                       sel;
  logic                       arm;
  logic                       hit;

  assign sel     = REACH && (cmd.slot == ID);
  assign arm     = cmd.add && sel && !valid;
  assign elapsed = now - start;
  assign hit     = tok && valid && (CMP_W'(elapsed) >= CMP_W'(interval));

  assign link_out.hit  = link_in.hit | hit;
  assign link_out.slot = hit ? ID : link_in.slot;
  assign link_out.once = hit ? once : link_in.once;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      once  <= 1'b0;
      tok   <= 1'b0;
    end else begin
      if (adv) begin
        tok <= tok_in;
      end
      if (arm) begin
        valid <= 1'b1;
        once  <= cmd.one_shot;
      end else if (cmd.del && sel) begin
        valid <= 1'b0;
      end else if (adv && hit && once) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (arm) begin
      interval <= cmd.interval;
      start    <= now;
    end else if (adv && hit && !once) begin
      start <= now;
    end
  end

endmodule

@@ rtl/multi_timer_expiry_table.sv @@
// Top level of the timer slot table: command decode, scan control and output
// register around a row of mte_cell instances. Uses mte_pkg.
//
//   channel  signals                          direction  payload
//   in       in_valid / in_stall / in_data    to block   mte_pkg::item_t
//   out      out_valid / out_stall / out_data from block mte_pkg::result_t
//   cfg      cfg_valid / cfg_ready / cfg_data to block   enable bit
//
// Add, delete, unused opcodes and ticks while disabled complete without a scan.
// An enabled tick passes a token down the cell row, one cell per cycle while
// the output is not stalled. A fire is held one step so the final one can
// carry last; in_stall is high during the scan and the flush that follows.
// Synchronous reset empties the table and clears enable.
module multi_timer_expiry_table #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mte_pkg::item_t    in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mte_pkg::result_t  out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  logic                 enable;
  logic                 scan;
  logic                 flush;
  logic [TIME_BITS-1:0] scan_now;
  logic [TIME_BITS-1:0] now;
  logic                 pend_v;
  mte_pkg::result_t     pend;
  mte_pkg::cmd_t        cmd;
  mte_pkg::link_t       links [NUM_SLOTS+1];
  logic [NUM_SLOTS:0]   tin;
  mte_pkg::link_t       link;
  mte_pkg::result_t     push_data;
  logic                 push;
  logic                 in_accept;
  logic                 start;
  logic                 step;
  logic                 adv;
  logic                 out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = scan | flush;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign start     = in_accept && (in_data.opcode == mte_pkg::OP_TICK) && enable;
  assign step      = scan && out_free;
  assign adv       = start || step;
  assign now       = scan ? scan_now : TIME_BITS'(in_data.now_time);

  assign cmd.add      = in_accept && (in_data.opcode == mte_pkg::OP_ADD);
  assign cmd.del      = in_accept && (in_data.opcode == mte_pkg::OP_DEL);
  assign cmd.slot     = in_data.slot;
  assign cmd.one_shot = in_data.one_shot;
  assign cmd.interval = in_data.interval;

  assign links[0] = '0;
  assign tin[0]   = start;
  assign link     = links[NUM_SLOTS];

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    mte_cell #(
      .IDX       (g),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .now      (now),
      .adv      (adv),
      .tok_in   (tin[g]),
      .tok      (tin[g+1]),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  always_comb begin
    push      = 1'b0;
    push_data = pend;
    if (step && link.hit && pend_v) begin
      push           = 1'b1;
      push_data.last = 1'b0;
    end else if (flush && out_free && pend_v) begin
      push           = 1'b1;
      push_data.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      scan      <= 1'b0;
      flush     <= 1'b0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        enable <= cfg_data;
      end
      if (start) begin
        scan <= 1'b1;
      end else if (step && tin[NUM_SLOTS]) begin
        scan  <= 1'b0;
        flush <= 1'b1;
      end else if (flush && out_free) begin
        flush <= 1'b0;
      end
      if (step && link.hit) begin
        pend_v <= 1'b1;
      end else if (flush && out_free) begin
        pend_v <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      scan_now <= TIME_BITS'(in_data.now_time);
    end
    if (step && link.hit) begin
      pend.fired_slot <= link.slot;
      pend.fired_once <= link.once;
      pend.last       <= 1'b0;
    end
    if (push) begin
      out_data <= push_data;
    end
  end

  a_token_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tin[NUM_SLOTS:1]))
    else $error("more than one scan token in the cell row");

  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    !(scan && flush))
    else $error("scan and flush active together");

  a_tick_disabled: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.opcode == mte_pkg::OP_TICK && !enable)
      |=> !in_stall)
    else $error("tick while disabled started a scan");

endmodule

@@ tb/sv/mte_checker.sv @@
// Scoreboard for the timer slot table: follows the item, result and enable
// transfers, predicts the fire results of each tick and compares them in order.
// Uses mte_pkg.
module mte_checker #(
  parameter int NUM_SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  mte_pkg::item_t   in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  mte_pkg::result_t out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_data,
  output int               outstanding,
  output int               errors
);

  logic                       scan_on;
  logic [NUM_SLOTS-1:0]       armed;
  logic [NUM_SLOTS-1:0]       single;
  logic [mte_pkg::WORD_W-1:0] period [NUM_SLOTS];
  logic [mte_pkg::WORD_W-1:0] origin [NUM_SLOTS];
  mte_pkg::result_t           fires_due [$];

  task automatic log_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic take_item(input mte_pkg::item_t it);
    logic [NUM_SLOTS-1:0]       hits;
    logic [mte_pkg::WORD_W-1:0] age;
    mte_pkg::result_t           r;
    int                         i;
    hits = '0;
    case (it.opcode)
      mte_pkg::OP_ADD: begin
        if (!armed[it.slot]) begin
          armed[it.slot]  = 1'b1;
          single[it.slot] = it.one_shot;
          period[it.slot] = it.interval;
          origin[it.slot] = it.now_time;
        end
      end
      mte_pkg::OP_DEL: begin
        armed[it.slot] = 1'b0;
      end
      mte_pkg::OP_TICK: begin
        if (scan_on) begin
          for (i = 0; i < NUM_SLOTS; i++) begin
            age = it.now_time - origin[i];
            if (armed[i] && age >= period[i]) hits[i] = 1'b1;
          end
          for (i = 0; i < NUM_SLOTS; i++) begin
            if (hits[i]) begin
              r.fired_slot = mte_pkg::SLOT_W'(i);
              r.fired_once = single[i];
              r.last       = (hits >> (i + 1)) == '0;
              fires_due.push_back(r);
              if (single[i]) armed[i] = 1'b0;
              else origin[i] = it.now_time;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_fire(input mte_pkg::result_t got);
    mte_pkg::result_t want;
    if (fires_due.size() == 0) begin
      log_mismatch($sformatf("fire from slot %0d with nothing pending", got.fired_slot));
      return;
    end
    want = fires_due.pop_front();
    if (got.fired_slot !== want.fired_slot)
      log_mismatch($sformatf("fired_slot got %0d want %0d", got.fired_slot, want.fired_slot));
    if (got.fired_once !== want.fired_once)
      log_mismatch($sformatf("fired_once got %0b want %0b (slot %0d)",
                             got.fired_once, want.fired_once, want.fired_slot));
    if (got.last !== want.last)
      log_mismatch($sformatf("last got %0b want %0b (slot %0d)",
                             got.last, want.last, want.fired_slot));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan_on = 1'b0;
      armed   = '0;
      single  = '0;
      errors  = 0;
      fires_due.delete();
    end else begin
      if (out_valid && !out_stall) check_fire(out_data);
      if (in_valid && !in_stall) take_item(in_data);
      if (cfg_valid && cfg_ready) scan_on = cfg_data;
    end
    outstanding <= fires_due.size();
  end

endmodule

@@ tb/sv/tb_multi_timer_expiry_table.sv @@
// Top of the timer slot table testbench: clock, reset, item and enable
// stimulus with random idling, and the verdict. Uses mte_pkg, the block and
// mte_checker.
module tb_multi_timer_expiry_table;

  localparam int         NUM_SLOTS   = 16;
  localparam int         SETTLE      = NUM_SLOTS + 8;
  localparam int         HOLD_CYCLES = 300;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam logic [1:0] OP_NONE     = 2'd3;

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  mte_pkg::item_t   in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  mte_pkg::result_t out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_data  = 1'b0;
  logic             hold_go   = 1'b0;
  int               outstanding;
  int               errors;

  logic [mte_pkg::WORD_W-1:0] wall;
  logic                       tx_calm;

  multi_timer_expiry_table #(
    .NUM_SLOTS(NUM_SLOTS),
    .TIME_BITS(32)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  mte_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .outstanding(outstanding),
    .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic mte_pkg::item_t timer_op(input logic [1:0] op,
                                              input logic [mte_pkg::SLOT_W-1:0] s,
                                              input logic once,
                                              input logic [mte_pkg::WORD_W-1:0] ivl,
                                              input logic [mte_pkg::WORD_W-1:0] t);
    mte_pkg::item_t it;
    it.opcode   = op;
    it.slot     = s;
    it.one_shot = once;
    it.interval = ivl;
    it.now_time = t;
    return it;
  endfunction

  function automatic logic [mte_pkg::SLOT_W-1:0] rand_slot();
    return mte_pkg::SLOT_W'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 24);
  endfunction

  task automatic send(input mte_pkg::item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every pending fire, then let a silent scan finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int goal);
    int             done;
    int             r;
    int             s;
    mte_pkg::item_t it;
    done = 0;
    while (done < goal) begin
      if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        // rearm the whole table with short intervals, then tick past them all
        for (s = 0; s < NUM_SLOTS; s++) begin
          send(timer_op(mte_pkg::OP_DEL, mte_pkg::SLOT_W'(s), rand_bit(), $urandom,
                        $urandom));
          send(timer_op(mte_pkg::OP_ADD, mte_pkg::SLOT_W'(s), rand_bit(),
                        $urandom_range(0, 3), wall));
        end
        wall += $urandom_range(4, 9);
        send(timer_op(mte_pkg::OP_TICK, rand_slot(), rand_bit(), $urandom, wall));
        done += 2 * NUM_SLOTS + 1;
        continue;
      end
      if (r < 4) begin
        drain();
        continue;
      end
      if (r < 40) begin
        wall += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30);
        it = timer_op(mte_pkg::OP_TICK, rand_slot(), rand_bit(), $urandom, wall);
      end else if (r < 46) begin
        it = timer_op(mte_pkg::OP_TICK, rand_slot(), rand_bit(), $urandom, $urandom);
      end else if (r < 72) begin
        it = timer_op(mte_pkg::OP_ADD, rand_slot(), rand_bit(),
                      ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 60),
                      ($urandom_range(0, 6) == 0) ? $urandom : wall);
      end else if (r < 92) begin
        it = timer_op(mte_pkg::OP_DEL, rand_slot(), rand_bit(), $urandom, $urandom);
      end else begin
        it = timer_op(OP_NONE, rand_slot(), rand_bit(), $urandom, $urandom);
      end
      send(it);
      done++;
    end
  endtask

  // receiver: short and long stalls, calm stretches, one long hold-off
  initial begin : sink
    int idle_left;
    int calm_left;
    int r;
    bit hold_used;
    idle_left = 0;
    calm_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_used) begin
        hold_used = 1'b1;
        idle_left = HOLD_CYCLES;
      end
      if (idle_left > 0) begin
        idle_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) calm_left = $urandom_range(30, 80);
          else if (r < 25) idle_left = $urandom_range(1, 3);
          else if (r < 30) idle_left = $urandom_range(8, 24);
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("multi_timer_expiry_table regression: fail");
    $finish;
  end

  initial begin : stimulus
    tx_calm = 1'b0;
    wall    = $urandom;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // disabled: an armed zero-interval slot stays silent
    send(timer_op(mte_pkg::OP_ADD, 4'd3, 1'b0, 32'd0, 32'd0));
    send(timer_op(mte_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, 32'd100));
    drain();
    write_enable(1'b1);

    send(timer_op(mte_pkg::OP_ADD, 4'd0, 1'b0, 32'd0, 32'd0));
    send(timer_op(mte_pkg::OP_ADD, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFF0));
    send(timer_op(mte_pkg::OP_ADD, 4'd0, 1'b1, 32'd5, 32'd77));        // occupied, no effect
    send(timer_op(OP_NONE, 4'hF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(timer_op(mte_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, 32'd0));
    send(timer_op(mte_pkg::OP_DEL, 4'd7, 1'b0, 32'd0, 32'd0));         // free slot
    send(timer_op(mte_pkg::OP_ADD, 4'd7, 1'b1, 32'd100, 32'hFFFF_FFC0));
    send(timer_op(mte_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, 32'h0000_0030)); // across the wrap
    send(timer_op(mte_pkg::OP_DEL, 4'd0, 1'b0, 32'd0, 32'd0));
    send(timer_op(mte_pkg::OP_DEL, 4'd3, 1'b0, 32'd0, 32'd0));
    send(timer_op(mte_pkg::OP_ADD, 4'd8, 1'b0, 32'd1, 32'hFFFF_FFFF));
    send(timer_op(mte_pkg::OP_TICK, 4'hF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFEF));
    send(timer_op(mte_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, 32'd0));
    send(timer_op(mte_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, 32'd1));
    drain();

    hold_go <= 1'b1;
    run_phase(110);
    drain();
    write_enable(1'b0);
    run_phase(50);
    drain();
    write_enable(1'b1);
    wall = 32'hFFFF_FE00;
    run_phase(200);
    drain();

    if (errors == 0 && outstanding == 0)
      $display("multi_timer_expiry_table regression: pass");
    else
      $display("multi_timer_expiry_table regression: fail");
    $finish;
  end

endmodule

@@ multi_timer_expiry_table.f @@
rtl/mte_pkg.sv
rtl/mte_cell.sv
rtl/multi_timer_expiry_table.sv
tb/sv/mte_checker.sv
tb/sv/tb_multi_timer_expiry_table.sv
